### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lbpg_pkg.sv
package lbpg_pkg;

  // Width of the burst repeat count and of the count reported back.
  localparam int COUNT_BITS = 16;

  // Lit time after reset.
  localparam int LIT_RESET = 500;

  // Command codes carried in each input word.
  typedef enum logic [2:0] {
    ACT_TICK         = 3'd0,
    ACT_FORCE_ON     = 3'd1,
    ACT_FORCE_OFF    = 3'd2,
    ACT_START_BURST  = 3'd3,
    ACT_START_TOGGLE = 3'd4
  } action_t;

  // Running mode, also reported on the output.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BURST  = 2'd1,
    MODE_TOGGLE = 2'd2
  } mode_t;

endpackage

### rtl/core/lbpg_if.sv
// Command channel: one tick or command per word.
interface lbpg_in_if
  import lbpg_pkg::*;
#(
  parameter int TIME_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            action;
  logic [TIME_BITS-1:0]  on_ticks;
  logic [TIME_BITS-1:0]  off_ticks;
  logic [COUNT_BITS-1:0] repeat_total;
  logic [TIME_BITS-1:0]  toggle_period;

  modport source (
    output valid, action, on_ticks, off_ticks, repeat_total, toggle_period,
    input  ready
  );
  modport sink (
    input  valid, action, on_ticks, off_ticks, repeat_total, toggle_period,
    output ready
  );
endinterface

// Status channel: one word per command word.
interface lbpg_out_if
  import lbpg_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  led_level;
  logic [1:0]            run_mode;
  logic [COUNT_BITS-1:0] cycles_left;

  modport source (
    output valid, led_level, run_mode, cycles_left,
    input  ready
  );
  modport sink (
    input  valid, led_level, run_mode, cycles_left,
    output ready
  );
endinterface

### rtl/core/led_blink_pattern_generator_top.sv
// Channel | Dir | Payload
// --------+-----+----------------------------------------------------------
// cmd     | in  | action, on_ticks, off_ticks, repeat_total, toggle_period
// status  | out | led_level, run_mode, cycles_left
//
// One status word per command word, one word per cycle while status words are taken.
// A word passes two registers: an input register, then the state update whose
// result the status register holds until taken.
// While a status word waits, one more word fits in the input register;
// after that cmd.ready stays low until the status word is taken.
// Reset (rst, synchronous) clears both valid flags and the LED state.
`include "assert_macros.svh"

module led_blink_pattern_generator_top
  import lbpg_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  lbpg_in_if.sink    cmd,
  lbpg_out_if.source status
);

  localparam int PHASE_BITS = TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] LIT_INIT = TIME_BITS'(LIT_RESET);

  // Input register
  logic                  s1_valid;
  logic [2:0]            s1_action;
  logic [TIME_BITS-1:0]  s1_on;
  logic [TIME_BITS-1:0]  s1_off;
  logic [COUNT_BITS-1:0] s1_reps;
  logic [TIME_BITS-1:0]  s1_period;

  // LED state
  mode_t                 mode_reg, mode_reg_next;
  logic                  led_reg, led_reg_next;
  logic [PHASE_BITS-1:0] phase_count, phase_count_next;
  logic [TIME_BITS-1:0]  lit_limit, lit_limit_next;
  logic [PHASE_BITS-1:0] cycle_limit, cycle_limit_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic [TIME_BITS-1:0]  period_reg, period_reg_next;

  logic                  out_valid;
  logic                  move;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [COUNT_BITS-1:0] remaining_dec;

  // Advance the input word into the state when the status slot is free
  assign move      = s1_valid && (!out_valid || status.ready);
  assign cmd.ready = !s1_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_action <= cmd.action;
      s1_on     <= cmd.on_ticks;
      s1_off    <= cmd.off_ticks;
      s1_reps   <= cmd.repeat_total;
      s1_period <= cmd.toggle_period;
    end
  end

  // Next state for the registered word
  always_comb begin
    mode_reg_next    = mode_reg;
    led_reg_next     = led_reg;
    phase_count_next = phase_count;
    lit_limit_next   = lit_limit;
    cycle_limit_next = cycle_limit;
    remaining_next   = remaining;
    period_reg_next  = period_reg;
    phase_inc        = phase_count + PHASE_BITS'(1);
    remaining_dec    = (remaining != '0) ? remaining - COUNT_BITS'(1) : remaining;

    unique case (s1_action)
      ACT_TICK: begin
        if (mode_reg == MODE_BURST) begin
          phase_count_next = phase_inc;
          if (phase_inc <= {1'b0, lit_limit}) begin
            led_reg_next = 1'b1;
          end else if (phase_inc <= cycle_limit) begin
            led_reg_next = 1'b0;
          end else begin
            // End of one on/off cycle: clear phase, use up one repeat
            phase_count_next = '0;
            remaining_next   = remaining_dec;
            if (remaining_dec == '0) begin
              mode_reg_next = MODE_IDLE;
            end
          end
        end else if (mode_reg == MODE_TOGGLE) begin
          phase_count_next = phase_inc;
          if (phase_inc >= {1'b0, period_reg}) begin
            led_reg_next     = !led_reg;
            phase_count_next = '0;
          end
        end
      end
      ACT_FORCE_ON: begin
        led_reg_next = 1'b1;
      end
      ACT_FORCE_OFF: begin
        led_reg_next = 1'b0;
      end
      ACT_START_BURST: begin
        // A zero repeat count starts nothing
        if (s1_reps != '0) begin
          lit_limit_next   = s1_on;
          cycle_limit_next = {1'b0, s1_on} + {1'b0, s1_off};
          remaining_next   = s1_reps;
          phase_count_next = '0;
          mode_reg_next    = MODE_BURST;
          led_reg_next     = 1'b1;
        end
      end
      ACT_START_TOGGLE: begin
        period_reg_next  = s1_period;
        phase_count_next = '0;
        mode_reg_next    = MODE_TOGGLE;
      end
      default: begin
      end
    endcase
  end

  // State register, loaded once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_IDLE;
      led_reg     <= 1'b0;
      phase_count <= '0;
      lit_limit   <= LIT_INIT;
      cycle_limit <= '0;
      remaining   <= '0;
      period_reg  <= '0;
    end else if (move) begin
      mode_reg    <= mode_reg_next;
      led_reg     <= led_reg_next;
      phase_count <= phase_count_next;
      lit_limit   <= lit_limit_next;
      cycle_limit <= cycle_limit_next;
      remaining   <= remaining_next;
      period_reg  <= period_reg_next;
    end
  end

  // Status valid: set on each update, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The state only changes together with a new status word
  assign status.valid       = out_valid;
  assign status.led_level   = led_reg;
  assign status.run_mode    = mode_reg;
  assign status.cycles_left = remaining;

  `ASSERT_CLK(a_burst_has_count,
    (mode_reg == MODE_BURST) |-> (remaining != '0),
    "burst with no cycles left")
  `ASSERT_CLK(a_burst_phase_bound,
    (mode_reg == MODE_BURST) |-> (phase_count <= cycle_limit),
    "burst phase past cycle limit")
  `ASSERT_CLK(a_state_holds,
    !move |=> ($stable(led_reg) && $stable(mode_reg) && $stable(remaining)),
    "state changed without a status word")
  `ASSERT_CLK_ALWAYS(a_accept_fills,
    (!rst && cmd.valid && cmd.ready) |=> (s1_valid || rst),
    "accepted word lost from input register")

endmodule
